// ===== hw/rtl/tgpr_pkg.sv =====
// ---------------------------------------------------------------------------
// tgpr_pkg
// Shared types, constants and the 8x8 font table of the text glyph renderer.
// ---------------------------------------------------------------------------
package tgpr_pkg;

	localparam int GLYPH_DIM  = 8;
	localparam int CODE_COUNT = 128;
	localparam int CODE_W     = $clog2(CODE_COUNT);
	localparam int GIDX_W     = $clog2(GLYPH_DIM);
	localparam int PIX_W      = GLYPH_DIM * GLYPH_DIM;
	localparam int CMD_DEPTH  = 2;

	localparam logic [7:0] NL_CODE     = 8'd10;
	localparam logic [7:0] FIRST_DRAWN = 8'd32;
	localparam logic [7:0] LAST_DRAWN  = 8'd127;
	localparam logic [15:0] CHAR_ADV   = 16'd8;

	localparam logic [11:0] WIDTH_RST  = 12'd240;
	localparam logic [11:0] HEIGHT_RST = 12'd320;
	localparam logic [7:0]  PITCH_RST  = 8'd10;

	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_PITCH  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [11:0] width;
		logic [11:0] height;
		logic [7:0]  pitch;
	} cfg_t;

	// One drawn character as handed from the front to the back.
	typedef struct packed {
		logic [15:0]           col;
		logic [15:0]           row;
		logic [CODE_W-1:0]     code;
		logic [15:0]           fg;
		logic [15:0]           bg;
		logic [GLYPH_DIM-1:0]  col_mask;
		logic [GLYPH_DIM-1:0]  row_mask;
		logic [GIDX_W-1:0]     last_r;
		logic [GIDX_W-1:0]     last_c;
	} cmd_t;

	// Whole glyph, row 0 in the top byte, MSB leftmost within a row.
	function automatic logic [PIX_W-1:0] glyph_bits(input logic [CODE_W-1:0] code);
		logic [PIX_W-1:0] g;
		unique case (code)
			7'd48:   g = 64'h386CC6D6C66C3800;
			7'd49:   g = 64'h307030303030FC00;
			7'd50:   g = 64'h78CC0C3860CCFC00;
			7'd51:   g = 64'h78CC0C380CCC7800;
			7'd52:   g = 64'h1C3C6CCCFE0C1E00;
			7'd53:   g = 64'hFCC0F80C0CCC7800;
			7'd54:   g = 64'h3860C0F8CCCC7800;
			7'd55:   g = 64'hFCCC0C1830303000;
			7'd56:   g = 64'h78CCCC78CCCC7800;
			7'd57:   g = 64'h78CCCC7C0C187000;
			7'd58:   g = 64'h0030300030300000;
			7'd65:   g = 64'h3078CCCCFCCCCC00;
			7'd66:   g = 64'hFC66667C6666FC00;
			7'd67:   g = 64'h3C66C0C0C0663C00;
			7'd68:   g = 64'hF86C6666666CF800;
			7'd69:   g = 64'hFE6268786862FE00;
			7'd72:   g = 64'hCCCCCCFCCCCCCC00;
			7'd73:   g = 64'h7830303030307800;
			7'd76:   g = 64'hF06060606266FE00;
			7'd79:   g = 64'h386CC6C6C66C3800;
			7'd83:   g = 64'h78CC60300CCC7800;
			7'd84:   g = 64'hFCB4303030307800;
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

// ===== hw/rtl/tgpr_cmd_queue.sv =====
// ---------------------------------------------------------------------------
// tgpr_cmd_queue
// Small flop queue of draw commands between the front and the back.
// ---------------------------------------------------------------------------
module tgpr_cmd_queue #(
	parameter int DEPTH = tgpr_pkg::CMD_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  tgpr_pkg::cmd_t   wr_data,
	output logic             full,
	input  logic             rd_en,
	output tgpr_pkg::cmd_t   rd_data,
	output logic             not_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	tgpr_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign do_wr     = wr_en && !full;
	assign do_rd     = rd_en && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/tgpr_front.sv =====
// ---------------------------------------------------------------------------
// tgpr_front
// Accepts characters, keeps the text cursor and turns drawable characters
// into clipped draw commands.
// ---------------------------------------------------------------------------
module tgpr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tgpr_pkg::cfg_t       cfg,
	input  logic                 accept,
	input  logic [7:0]           char_code,
	input  logic                 string_start,
	input  logic [15:0]          start_x,
	input  logic [15:0]          start_y,
	input  logic [15:0]          fg_color,
	input  logic [15:0]          back_color,
	output logic                 cmd_push,
	output tgpr_pkg::cmd_t       cmd
);

	localparam int GD = tgpr_pkg::GLYPH_DIM;
	localparam int GW = tgpr_pkg::GIDX_W;

	logic [15:0]   col_q;
	logic [15:0]   row_q;
	logic [15:0]   origin_q;
	logic [15:0]   col_cur;
	logic [15:0]   row_cur;
	logic [15:0]   origin_cur;
	logic [15:0]   col_adv;
	logic [15:0]   row_adv;
	logic          wrap;
	logic          is_nl;
	logic          is_drawn;
	logic [GD-1:0] col_mask;
	logic [GD-1:0] row_mask;
	logic [GW-1:0] last_r;
	logic [GW-1:0] last_c;

	always_comb begin
		col_cur    = string_start ? start_x : col_q;
		row_cur    = string_start ? start_y : row_q;
		origin_cur = string_start ? start_x : origin_q;
		is_nl      = (char_code == tgpr_pkg::NL_CODE);
		is_drawn   = (char_code >= tgpr_pkg::FIRST_DRAWN) &&
		             (char_code <= tgpr_pkg::LAST_DRAWN);
		col_adv    = col_cur + tgpr_pkg::CHAR_ADV;
		row_adv    = row_cur + {8'd0, cfg.pitch};
		// signed compare against width-8, so a narrow screen wraps every time
		wrap       = $signed({1'b0, col_adv}) >=
		             ($signed({5'd0, cfg.width}) - 17'sd8);
	end

	// Visibility is separable: a pixel shows iff its row and its column do.
	always_comb begin
		logic [15:0] px;
		logic [15:0] py;
		last_r = '0;
		last_c = '0;
		for (int i = 0; i < GD; i++) begin
			px          = col_cur + 16'(i);
			py          = row_cur + 16'(i);
			col_mask[i] = (px < {4'd0, cfg.width});
			row_mask[i] = (py < {4'd0, cfg.height});
			if (col_mask[i]) begin
				last_c = GW'(i);
			end
			if (row_mask[i]) begin
				last_r = GW'(i);
			end
		end
	end

	assign cmd_push = accept && is_drawn && (col_mask != '0) && (row_mask != '0);

	always_comb begin
		cmd.col      = col_cur;
		cmd.row      = row_cur;
		cmd.code     = char_code[tgpr_pkg::CODE_W-1:0];
		cmd.fg       = fg_color;
		cmd.bg       = back_color;
		cmd.col_mask = col_mask;
		cmd.row_mask = row_mask;
		cmd.last_r   = last_r;
		cmd.last_c   = last_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			origin_q <= '0;
		end else if (accept) begin
			origin_q <= origin_cur;
			if (is_nl || wrap) begin
				col_q <= origin_cur;
				row_q <= row_adv;
			end else begin
				col_q <= col_adv;
				row_q <= row_cur;
			end
		end
	end

endmodule

// ===== hw/rtl/tgpr_back.sv =====
// ---------------------------------------------------------------------------
// tgpr_back
// Walks one glyph cell per cycle in row-major order, holding while an unpopped
// pixel waits, and registers each visible pixel for the result queue interface.
// ---------------------------------------------------------------------------
module tgpr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	input  tgpr_pkg::cmd_t  cmd_head,
	output logic            cmd_pop,
	output logic            empty,
	input  logic            pop,
	output logic [11:0]     pixel_x,
	output logic [11:0]     pixel_y,
	output logic [15:0]     pixel_color,
	output logic            last_pixel
);

	localparam int GW = tgpr_pkg::GIDX_W;
	localparam int IW = 2 * GW;
	localparam logic [IW-1:0] LAST_IDX = IW'(tgpr_pkg::PIX_W - 1);

	tgpr_pkg::cmd_t              cmd_q;
	logic [tgpr_pkg::PIX_W-1:0]  glyph_q;
	logic [IW-1:0]               idx_q;
	logic                        busy_q;
	logic                        out_valid_q;
	logic [GW-1:0]               r;
	logic [GW-1:0]               c;
	logic                        can_step;
	logic                        done_step;
	logic                        vis;
	logic                        bit_set;

	assign r         = idx_q[IW-1:GW];
	assign c         = idx_q[GW-1:0];
	assign can_step  = busy_q && (!out_valid_q || pop);
	assign done_step = can_step && (idx_q == LAST_IDX);
	assign vis       = cmd_q.row_mask[r] && cmd_q.col_mask[c];
	assign bit_set   = glyph_q[~idx_q];
	assign cmd_pop   = cmd_valid && (!busy_q || done_step);
	assign empty     = !out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q   <= cmd_head;
			glyph_q <= tgpr_pkg::glyph_bits(cmd_head.code);
		end
		if (can_step && vis) begin
			pixel_x     <= 12'(cmd_q.col + 16'(c));
			pixel_y     <= 12'(cmd_q.row + 16'(r));
			pixel_color <= bit_set ? cmd_q.fg : cmd_q.bg;
			last_pixel  <= (r == cmd_q.last_r) && (c == cmd_q.last_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && !pop) || (can_step && vis);
			if (cmd_pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (can_step) begin
				busy_q <= !done_step;
				idx_q  <= idx_q + 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/text_glyph_pixel_renderer.sv =====
// ---------------------------------------------------------------------------
// text_glyph_pixel_renderer
// 8x8 bitmap font text renderer: characters in, clipped pixel writes out.
// ---------------------------------------------------------------------------
//  channel    handshake                fields
//  input      push / full              char_code string_start start_x start_y
//                                      fg_color back_color
//  result     empty / pop              pixel_x pixel_y pixel_color last_pixel
//  config     cfg_we                   cfg_index cfg_data
//
//  A drawn character occupies the pixel walker for all 64 glyph cells (one
//  glyph cell per cycle, visible or not); an idle walker first loads the
//  command, back to back characters load as the last cell is walked.
//  Result stalls hold the walker. Newlines, non-drawn codes and fully
//  clipped glyphs never enter the walker.
//  full rises only when the command queue between front and walker is full.
//  Reset puts the cursor and origin at zero and the registers at 240/320/10.
// ---------------------------------------------------------------------------
module text_glyph_pixel_renderer #(
	parameter int CMD_DEPTH = tgpr_pkg::CMD_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_code,
	input  logic        string_start,
	input  logic [15:0] start_x,
	input  logic [15:0] start_y,
	input  logic [15:0] fg_color,
	input  logic [15:0] back_color,
	output logic        empty,
	input  logic        pop,
	output logic [11:0] pixel_x,
	output logic [11:0] pixel_y,
	output logic [15:0] pixel_color,
	output logic        last_pixel,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data
);

	tgpr_pkg::cfg_t cfg_q;
	tgpr_pkg::cmd_t front_cmd;
	tgpr_pkg::cmd_t head_cmd;
	logic           accept;
	logic           cmd_push;
	logic           cmd_pop;
	logic           cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= tgpr_pkg::WIDTH_RST;
			cfg_q.height <= tgpr_pkg::HEIGHT_RST;
			cfg_q.pitch  <= tgpr_pkg::PITCH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tgpr_pkg::CFG_WIDTH:  cfg_q.width  <= cfg_data;
				tgpr_pkg::CFG_HEIGHT: cfg_q.height <= cfg_data;
				tgpr_pkg::CFG_PITCH:  cfg_q.pitch  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign accept = push && !full;

	tgpr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.accept       (accept),
		.char_code    (char_code),
		.string_start (string_start),
		.start_x      (start_x),
		.start_y      (start_y),
		.fg_color     (fg_color),
		.back_color   (back_color),
		.cmd_push     (cmd_push),
		.cmd          (front_cmd)
	);

	tgpr_cmd_queue #(
		.DEPTH (CMD_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cmd_push),
		.wr_data   (front_cmd),
		.full      (full),
		.rd_en     (cmd_pop),
		.rd_data   (head_cmd),
		.not_empty (cmd_valid)
	);

	tgpr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_head    (head_cmd),
		.cmd_pop     (cmd_pop),
		.empty       (empty),
		.pop         (pop),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

endmodule
